// ===== rtl/egbw_pkg.sv =====
// ----------------------------------------------------------------------------
// egbw_pkg: shared types and constants for the Exp-Golomb bit writer
// Operation codes, field widths and saturation limits used by the channel
// interfaces and the core.
// ----------------------------------------------------------------------------
package egbw_pkg;

  localparam int MAX_FIXED_BITS = 32;
  localparam int BYTE_W         = 8;
  localparam int MAX_BYTES      = 4;
  localparam int VALUE_W        = 33;
  localparam int BIT_COUNT_W    = 6;
  localparam int CODE_NUM_W     = 16;
  // Widest pending-plus-codeword word, rounded up to whole bytes
  localparam int ACC_W          = MAX_FIXED_BITS + BYTE_W;
  localparam int PEND_W         = 3;
  localparam int LEN_W          = 6;
  localparam int CNT_W          = 3;

  typedef logic [1:0] op_t;

  localparam op_t OP_UE    = 2'd0;
  localparam op_t OP_SE    = 2'd1;
  localparam op_t OP_FIXED = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [BIT_COUNT_W-1:0]    bit_count_t;
  typedef logic [BYTE_W-1:0]         byte_t;

  localparam value_t     UE_MAX    = 33'sd65534;
  localparam value_t     SE_MAX    = 33'sd32767;
  localparam bit_count_t FIXED_MAX = BIT_COUNT_W'(MAX_FIXED_BITS);

endpackage

// ===== rtl/egbw_if.sv =====
// ----------------------------------------------------------------------------
// egbw_if: valid/ready channels of the Exp-Golomb bit writer
// egbw_elem_if carries one syntax element, egbw_byte_if one stream byte.
// ----------------------------------------------------------------------------
interface egbw_elem_if;
  logic                  valid;
  logic                  ready;
  egbw_pkg::op_t         operation;
  egbw_pkg::value_t      value;
  egbw_pkg::bit_count_t  bit_count;

  modport source (output valid, output operation, output value, output bit_count,
                  input ready);
  modport sink   (input valid, input operation, input value, input bit_count,
                  output ready);
endinterface

interface egbw_byte_if;
  logic             valid;
  logic             ready;
  egbw_pkg::byte_t  out_byte;
  logic             last_in_run;

  modport source (output valid, output out_byte, output last_in_run, input ready);
  modport sink   (input valid, input out_byte, input last_in_run, output ready);
endinterface

// ===== rtl/exp_golomb_bit_writer_core.sv =====
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_core: ue(v) / se(v) / u(n) codeword bit packer
// Forms one codeword per syntax element, appends it MSB-first to the
// pending partial byte and emits every completed byte in stream order.
//
//   channel  direction  payload                          handshake
//   elem     in         operation, value, bit_count      valid / ready
//   stream   out        out_byte, last_in_run            valid / ready
//
// An element is taken into an input register, where it is coded and packed,
// and its completed bytes (0 to 4) land in a byte buffer that drains one
// byte per cycle while stream.ready is high. One element can enter every
// cycle while the buffer can take its bytes: when it is empty or handing
// over its last byte. Elements that complete no byte never wait on the buffer.
// Synchronous reset clears the pending bits and empties both registers.
// A stalled stream holds the buffer; an element that completes bytes then
// waits in the input register and elem.ready drops.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_core (
  input  logic                clk,
  input  logic                rst,
  egbw_elem_if.sink           elem,
  egbw_byte_if.source         stream
);

  // Input register
  logic                                  in_vld;
  egbw_pkg::op_t                         op_r;
  egbw_pkg::value_t                      val_r;
  egbw_pkg::bit_count_t                  bc_r;

  // Bit packing state
  logic [egbw_pkg::PEND_W-1:0]           pend;
  logic [egbw_pkg::BYTE_W-2:0]           partial;

  // Byte buffer, entry MAX_BYTES-1 goes out first
  logic [egbw_pkg::MAX_BYTES-1:0][egbw_pkg::BYTE_W-1:0] bytes_q;
  logic [egbw_pkg::CNT_W-1:0]            rem;

  // Coding datapath
  logic [egbw_pkg::CODE_NUM_W-1:0]       code_num;
  logic [egbw_pkg::CODE_NUM_W-1:0]       m;
  logic [egbw_pkg::CODE_NUM_W-1:0]       se_mag;
  egbw_pkg::value_t                      se_clip;
  logic [3:0]                            lead;
  logic [egbw_pkg::MAX_FIXED_BITS-1:0]   code;
  logic [egbw_pkg::LEN_W-1:0]            len;
  egbw_pkg::bit_count_t                  fix_len;
  logic [egbw_pkg::LEN_W-1:0]            total;
  logic [egbw_pkg::ACC_W-1:0]            acc;
  logic [egbw_pkg::ACC_W-1:0]            aligned;
  logic [egbw_pkg::BYTE_W-2:0]           pend_mask;
  logic [egbw_pkg::BYTE_W-2:0]           keep_mask;
  logic [egbw_pkg::CNT_W-1:0]            nbytes;
  logic                                  take;
  logic                                  buf_free;
  logic                                  advance;

  always_comb begin
    code_num = '0;
    se_clip  = '0;
    se_mag   = '0;
    fix_len  = '0;
    code     = '0;
    len      = '0;

    // ue(v): clamp into 0..UE_MAX
    if (val_r < 0) begin
      code_num = '0;
    end else if (val_r > egbw_pkg::UE_MAX) begin
      code_num = egbw_pkg::CODE_NUM_W'(egbw_pkg::UE_MAX);
    end else begin
      code_num = val_r[egbw_pkg::CODE_NUM_W-1:0];
    end

    // se(v): clamp, then positive v -> 2v-1, non-positive v -> -2v
    if (op_r == egbw_pkg::OP_SE) begin
      if (val_r > egbw_pkg::SE_MAX) begin
        se_clip = egbw_pkg::SE_MAX;
      end else if (val_r < -egbw_pkg::SE_MAX) begin
        se_clip = -egbw_pkg::SE_MAX;
      end else begin
        se_clip = val_r;
      end
      if (se_clip > 0) begin
        se_mag   = se_clip[egbw_pkg::CODE_NUM_W-1:0];
        code_num = {se_mag[egbw_pkg::CODE_NUM_W-2:0], 1'b0} - 16'd1;
      end else begin
        se_mag   = egbw_pkg::CODE_NUM_W'(-se_clip);
        code_num = {se_mag[egbw_pkg::CODE_NUM_W-2:0], 1'b0};
      end
    end

    m = code_num + 16'd1;

    // Position of the leading one of codeNum + 1
    lead = '0;
    for (int k = 0; k < egbw_pkg::CODE_NUM_W; k++) begin
      if (m[k]) begin
        lead = 4'(k);
      end
    end

    if (bc_r > egbw_pkg::FIXED_MAX) begin
      fix_len = egbw_pkg::FIXED_MAX;
    end else begin
      fix_len = bc_r;
    end

    case (op_r)
      egbw_pkg::OP_UE, egbw_pkg::OP_SE: begin
        code = {16'd0, m};
        len  = {1'b0, lead, 1'b1};
      end
      egbw_pkg::OP_FIXED: begin
        len = fix_len;
        if (fix_len == '0) begin
          code = '0;
        end else begin
          code = val_r[egbw_pkg::MAX_FIXED_BITS-1:0] &
                 (32'hFFFF_FFFF >> (6'd32 - fix_len));
        end
      end
      default: begin
        // unknown operation: write nothing
        code = '0;
        len  = '0;
      end
    endcase
  end

  always_comb begin
    pend_mask = 7'((8'd1 << pend) - 8'd1);
    total     = egbw_pkg::LEN_W'(pend) + len;
    acc       = ({33'd0, partial & pend_mask} << len) |
                {8'd0, code};
    // Move the first pending bit to the top of the word
    aligned   = acc << (6'd40 - total);
    nbytes    = total[egbw_pkg::LEN_W-1:egbw_pkg::PEND_W];
    keep_mask = 7'((8'd1 << total[egbw_pkg::PEND_W-1:0]) - 8'd1);
  end

  assign take     = stream.valid && stream.ready;
  assign buf_free = (rem == '0) || ((rem == 3'd1) && stream.ready);
  assign advance  = in_vld && ((nbytes == '0) || buf_free);

  assign elem.ready         = !in_vld || advance;
  assign stream.valid       = (rem != '0);
  assign stream.out_byte    = bytes_q[egbw_pkg::MAX_BYTES-1];
  assign stream.last_in_run = (rem == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (elem.ready) begin
      in_vld <= elem.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (elem.valid && elem.ready) begin
      op_r  <= elem.operation;
      val_r <= elem.value;
      bc_r  <= elem.bit_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      partial <= '0;
    end else if (advance) begin
      pend    <= total[egbw_pkg::PEND_W-1:0];
      partial <= acc[egbw_pkg::BYTE_W-2:0] & keep_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (advance && (nbytes != '0)) begin
      rem <= nbytes;
    end else if (take) begin
      rem <= rem - 3'd1;
    end
  end

  // Load the completed bytes, or advance to the next one per transaction
  always_ff @(posedge clk) begin
    if (advance && (nbytes != '0)) begin
      bytes_q <= aligned[egbw_pkg::ACC_W-1:egbw_pkg::BYTE_W];
    end else if (take) begin
      bytes_q <= {bytes_q[egbw_pkg::MAX_BYTES-2:0], 8'd0};
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: exp_golomb_bit_writer_core
// Drives ue(v), se(v), u(n) and unknown-operation syntax elements into the
// element channel in random bursts. The bytes each element must complete
// are computed as it is accepted and then compared with the stream channel.
// The stream side stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;
  import egbw_pkg::*;

  typedef struct {
    op_t        operation;
    value_t     value;
    bit_count_t bit_count;
  } element_t;

  typedef struct {
    byte_t data;
    logic  last_in_run;
  } stream_byte_t;

  logic clk;
  logic rst;

  egbw_elem_if elem_ch ();
  egbw_byte_if byte_ch ();

  exp_golomb_bit_writer_core dut (
    .clk    (clk),
    .rst    (rst),
    .elem   (elem_ch),
    .stream (byte_ch)
  );

  element_t     element_backlog[$];
  stream_byte_t expected_bytes[$];
  int           error_count = 0;

  // Bits still waiting for a byte to fill, right-aligned.
  byte_t        partial_bits = '0;
  int           pend_count   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("exp_golomb_bit_writer_core verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Form the codeword for one element, append it to the pending bits and
  // queue every byte that completes.
  function automatic void pack_element(element_t e);
    longint          sv;
    longint unsigned code_num;
    logic [63:0]     code;
    logic [63:0]     acc;
    int              len;
    int              lz;
    int              emitted;
    sv       = longint'(e.value);
    code     = '0;
    code_num = 0;
    len      = 0;
    emitted  = 0;
    case (e.operation)
      OP_UE: begin
        if (sv < 0) sv = 0;
        if (sv > longint'(UE_MAX)) sv = longint'(UE_MAX);
        code_num = sv;
      end
      OP_SE: begin
        if (sv > longint'(SE_MAX)) sv = longint'(SE_MAX);
        if (sv < -longint'(SE_MAX)) sv = -longint'(SE_MAX);
        code_num = (sv > 0) ? 2 * sv - 1 : -2 * sv;
      end
      OP_FIXED: begin
        len  = (e.bit_count > MAX_FIXED_BITS) ? MAX_FIXED_BITS : int'(e.bit_count);
        code = {31'b0, e.value} & ((64'd1 << len) - 64'd1);
      end
      default: return;
    endcase
    if (e.operation != OP_FIXED) begin
      lz = 0;
      while (lz < 16 && ((code_num + 1) >> (lz + 1)) != 0) lz++;
      code = code_num + 1;
      len  = 2 * lz + 1;
    end
    acc = ((64'(partial_bits) & ((64'd1 << pend_count) - 64'd1)) << len) | code;
    pend_count += len;
    while (pend_count >= BYTE_W) begin
      pend_count -= BYTE_W;
      expected_bytes.push_back('{data: byte_t'(acc >> pend_count), last_in_run: 1'b0});
      emitted++;
    end
    if (emitted > 0) expected_bytes[$].last_in_run = 1'b1;
    partial_bits = byte_t'(acc & ((64'd1 << pend_count) - 64'd1));
  endfunction

  function automatic value_t wide_value();
    return value_t'({1'($urandom_range(0, 1)), 32'($urandom())});
  endfunction

  function automatic value_t pick_value(op_t op);
    int pick;
    pick = $urandom_range(0, 9);
    case (op)
      OP_UE: begin
        if (pick < 5) return value_t'($urandom_range(0, 300));
        if (pick < 8) return value_t'($urandom_range(0, 70000));
        if (pick == 8) return wide_value();
        return value_t'($urandom_range(65530, 65540));
      end
      OP_SE: begin
        if (pick < 5) return value_t'(longint'($urandom_range(0, 600)) - 300);
        if (pick < 8) return value_t'(longint'($urandom_range(0, 70000)) - 35000);
        if (pick == 8) return wide_value();
        if ($urandom_range(0, 1)) return value_t'($urandom_range(32766, 32769));
        return value_t'(-longint'($urandom_range(32766, 32769)));
      end
      default: return wide_value();
    endcase
  endfunction

  function automatic bit_count_t pick_bit_count(op_t op);
    int pick;
    pick = $urandom_range(0, 19);
    if (op != OP_FIXED) return bit_count_t'($urandom_range(0, 63));
    if (pick < 12) return bit_count_t'($urandom_range(1, 32));
    if (pick < 18) return bit_count_t'($urandom_range(1, 8));
    if (pick == 18) return '0;
    return bit_count_t'($urandom_range(33, 63));
  endfunction

  task automatic queue_element(input op_t op, input value_t v, input bit_count_t n);
    element_backlog.push_back('{operation: op, value: v, bit_count: n});
  endtask

  // Element driver: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      elem_ch.valid <= 1'b0;
      burst_left    <= $urandom_range(1, 12);
      gap_left      <= 0;
    end else if (!elem_ch.valid || elem_ch.ready) begin
      if (elem_ch.valid)
        pack_element('{operation: elem_ch.operation, value: elem_ch.value,
                       bit_count: elem_ch.bit_count});
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        elem_ch.valid <= 1'b0;
      end else if (element_backlog.size() != 0) begin
        elem_ch.valid     <= 1'b1;
        elem_ch.operation <= element_backlog[0].operation;
        elem_ch.value     <= element_backlog[0].value;
        elem_ch.bit_count <= element_backlog[0].bit_count;
        void'(element_backlog.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        elem_ch.valid <= 1'b0;
      end
    end
  end

  // Stream monitor: check each transaction, then pick the next ready value.
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                    byte_ch.out_byte, byte_ch.last_in_run));
        end else begin
          if (byte_ch.out_byte !== expected_bytes[0].data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      byte_ch.out_byte, expected_bytes[0].data));
          if (byte_ch.last_in_run !== expected_bytes[0].last_in_run)
            report_mismatch($sformatf("last_in_run %0b, expected %0b on byte %02h",
                                      byte_ch.last_in_run, expected_bytes[0].last_in_run,
                                      expected_bytes[0].data));
          void'(expected_bytes.pop_front());
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: byte_ch.ready <= 1'b1;
        1: byte_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            byte_ch.ready <= 1'b0;
          end else begin
            stall_left = $urandom_range(0, 6);
            byte_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin
    int   accepted_count;
    op_t  op;
    elem_ch.valid     = 1'b0;
    elem_ch.operation = OP_NONE;
    elem_ch.value     = '0;
    elem_ch.bit_count = '0;
    byte_ch.ready     = 1'b0;
    rst               = 1'b1;

    // ue extremes, saturation and negative inputs
    queue_element(OP_UE, value_t'(0), '0);
    queue_element(OP_UE, value_t'(1), bit_count_t'(63));
    queue_element(OP_UE, value_t'(2), '0);
    queue_element(OP_UE, value_t'(65534), '0);
    queue_element(OP_UE, value_t'(65535), '0);
    queue_element(OP_UE, value_t'(33'h0_FFFF_FFFF), '0);
    queue_element(OP_UE, value_t'(-1), '0);
    queue_element(OP_UE, value_t'(33'h1_0000_0000), '0);
    // se around zero and past both clamp limits
    queue_element(OP_SE, value_t'(0), '0);
    queue_element(OP_SE, value_t'(1), '0);
    queue_element(OP_SE, value_t'(-1), '0);
    queue_element(OP_SE, value_t'(32767), '0);
    queue_element(OP_SE, value_t'(-32767), '0);
    queue_element(OP_SE, value_t'(32768), '0);
    queue_element(OP_SE, value_t'(-32768), '0);
    queue_element(OP_SE, value_t'(33'h0_FFFF_FFFF), '0);
    queue_element(OP_SE, value_t'(33'h1_0000_0000), '0);
    // u(n): empty field, single bit, full width and oversized counts
    queue_element(OP_FIXED, value_t'(33'h1_FFFF_FFFF), '0);
    queue_element(OP_FIXED, value_t'(1), bit_count_t'(1));
    queue_element(OP_FIXED, value_t'(33'h0_FFFF_FFFF), bit_count_t'(32));
    queue_element(OP_FIXED, value_t'(33'h1_2345_6789), bit_count_t'(33));
    queue_element(OP_FIXED, value_t'(0), bit_count_t'(63));
    queue_element(OP_FIXED, value_t'(8'h55), bit_count_t'(7));
    // unknown operation leaves the pending bits alone
    queue_element(OP_NONE, value_t'(33'h1_FFFF_FFFF), bit_count_t'(63));
    queue_element(OP_FIXED, value_t'(8'hA5), bit_count_t'(8));

    accepted_count = 0;
    while (accepted_count < 400) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6:  op = OP_UE;
        7, 8, 9, 10, 11, 12:  op = OP_SE;
        13, 14, 15, 16, 17, 18: op = OP_FIXED;
        default: op = OP_NONE;
      endcase
      queue_element(op, pick_value(op), pick_bit_count(op));
      if (op != OP_NONE) accepted_count++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (element_backlog.size() != 0 || elem_ch.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("exp_golomb_bit_writer_core verification clean");
    end else begin
      $display("exp_golomb_bit_writer_core verification failed");
    end
    $finish;
  end

endmodule
